// ===== hw/rtl/float32_divider_truncating_defines.svh =====
// Assertion macros for the truncating divider
`ifndef FLOAT32_DIVIDER_TRUNCATING_DEFINES_SVH
`define FLOAT32_DIVIDER_TRUNCATING_DEFINES_SVH
// implication checked every clock, off during reset
`define FDT_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define FDT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/fdt_pkg.sv =====
// Shared types and constants for the truncating divider
package fdt_pkg;
  localparam int unsigned QUOTIENT_BITS = 24;
  localparam int unsigned FRAC_W = 23;
  localparam int unsigned EXP_W  = 8;
  localparam int unsigned SIG_W  = 24;
  localparam int unsigned REM_W  = 26;
  localparam logic [31:0] QNAN_ZZ = 32'h7FFFFFFF;
  localparam logic [31:0] INF_NEG = 32'hFF800000;
  localparam logic [31:0] INF_POS = 32'h7F800000;

  typedef struct packed {
    logic              valid;
    logic              sign;
    logic [9:0]        exp;
    logic [REM_W-1:0]  rem;
    logic [SIG_W-1:0]  den;
    logic [SIG_W-1:0]  q;
    logic              special;
    logic [31:0]       spec_word;
    logic              dbz;
  } fdt_cell_t;
endpackage

// ===== hw/rtl/fdt_cell.sv =====
// One restoring division step with its pipeline register
module fdt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fdt_pkg::fdt_cell_t in_c,
  output fdt_pkg::fdt_cell_t out_c
);
  fdt_pkg::fdt_cell_t c_r, c_nxt;
  logic [fdt_pkg::REM_W-1:0] diff;
  logic ge;

  always_comb begin
    diff  = in_c.rem - {2'b00, in_c.den};
    ge    = in_c.rem >= {2'b00, in_c.den};
    c_nxt = in_c;
    c_nxt.q = {in_c.q[fdt_pkg::SIG_W-2:0], ge};
    c_nxt.rem = {(ge ? diff[fdt_pkg::REM_W-2:0] : in_c.rem[fdt_pkg::REM_W-2:0]), 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign out_c = c_r;
endmodule

// ===== hw/rtl/float32_divider_truncating.sv =====
// Top level: pipelined truncating single-precision divider
//  channel | ports                                             | dir
//  in      | in_valid in_stall in_dividend in_divisor           | in
//  out     | out_valid out_stall out_quotient out_divide_by_zero | out
//          |   out_exponent_out_of_range                       |
// One word per cycle unless the row is stalled; QUOTIENT_BITS + 1 register
// stages (one divide-step cell per quotient bit, then the output register).
// Synchronous active-low reset empties the row.
// out_stall freezes the whole row while out_valid is high; in_stall is high exactly then.
`include "float32_divider_truncating_defines.svh"
module float32_divider_truncating (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_dividend,
  input  logic [31:0] in_divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_quotient,
  output logic        out_divide_by_zero,
  output logic        out_exponent_out_of_range
);
  fdt_pkg::fdt_cell_t head;
  fdt_pkg::fdt_cell_t chain [fdt_pkg::QUOTIENT_BITS+1];
  logic en;
  logic a_zero, b_zero;
  fdt_pkg::fdt_cell_t last;
  logic [9:0] e_fin;
  logic [22:0] frac;
  logic norm;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    a_zero = in_dividend[30:0] == 31'd0;
    b_zero = in_divisor[30:0] == 31'd0;
    head.valid = in_valid;
    head.sign  = in_dividend[31] ^ in_divisor[31];
    head.exp   = {2'b00, in_dividend[30:23]} - {2'b00, in_divisor[30:23]} + 10'd127;
    head.rem   = {3'b001, in_dividend[22:0]};
    head.den   = {1'b1, in_divisor[22:0]};
    head.q     = '0;
    head.special = a_zero || b_zero;
    head.dbz   = b_zero;
    if (b_zero) begin
      head.spec_word = a_zero ? fdt_pkg::QNAN_ZZ :
                       (in_dividend[31] ? fdt_pkg::INF_NEG : fdt_pkg::INF_POS);
    end else begin
      head.spec_word = {head.sign, 31'd0};
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < fdt_pkg::QUOTIENT_BITS; g++) begin : g_row
    fdt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .in_c(chain[g]), .out_c(chain[g+1])
    );
  end

  assign last = chain[fdt_pkg::QUOTIENT_BITS];

  always_comb begin
    norm  = !last.q[fdt_pkg::SIG_W-1];
    e_fin = norm ? last.exp - 10'd1 : last.exp;
    frac  = norm ? {last.q[21:0], 1'b0} : last.q[22:0];
  end

  logic dbz_r;
  logic [31:0] q_r;
  logic oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dbz_r <= last.dbz;
      q_r   <= last.special ? last.spec_word : {last.sign, e_fin[7:0], frac};
      oor_r <= !last.special && ($signed(e_fin) < 10'sd1 || $signed(e_fin) > 10'sd254);
    end
  end

  assign out_quotient              = q_r;
  assign out_divide_by_zero        = dbz_r;
  assign out_exponent_out_of_range = oor_r;

  `FDT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(q_r))
  `FDT_ASSERT_IMP(a_dbz_flag, clk, rst_n, out_valid && out_divide_by_zero, !out_exponent_out_of_range)
  `FDT_ASSERT_IMP(a_stall_tie, clk, rst_n, in_stall, out_valid && out_stall)
endmodule
